// ===== rtl/sa_pkg.sv =====
// ============================================================================
// sa_pkg
// Shared types and constants of the segment allocator: table geometry,
// status and policy codes, cell commands and controller states.
// ============================================================================
`default_nettype none

package sa_pkg;

    // Table geometry and field widths
    localparam int MAX_SEG     = 32;
    localparam int IDX_W       = $clog2(MAX_SEG);
    localparam int CNT_W       = $clog2(MAX_SEG + 1);
    localparam int OFS_W       = 16;
    localparam int LEN_W       = OFS_W + 1;
    localparam int POL_W       = 2;
    localparam int STAT_W      = 2;
    localparam int REG_IDX_W   = 1;

    localparam logic [LEN_W-1:0] RESET_HEAP = LEN_W'(128);
    localparam logic [LEN_W-1:0] HEAP_MAX   = LEN_W'(1) << OFS_W;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIT_POLICY = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_SIZE  = 1'b1;

    // Fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADOFS = 2'd3;

    // One table entry
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             used;
    } seg_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_OPEN,
        CMD_DROP,
        CMD_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        seg_t             seg;
    } cell_cmd_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_ADECIDE,
        S_AWR_REM,
        S_AWR_HEAD,
        S_FSCAN,
        S_FCLR,
        S_FNEXT,
        S_FDROPN,
        S_FPREV,
        S_FDROPK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sa_if.sv =====
// ============================================================================
// sa_req_if / sa_rsp_if
// Valid/ready channels carrying allocator requests and results.
// ============================================================================
`default_nettype none

interface sa_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [16:0] alloc_size;
    logic [15:0] free_offset;

    modport source (output valid, mode, alloc_size, free_offset, input ready);
    modport sink   (input valid, mode, alloc_size, free_offset, output ready);
endinterface

interface sa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/sa_cell.sv =====
// ============================================================================
// sa_cell
// One table entry of the segment chain. Takes its left or right neighbor
// on a shift command, broadcast data when addressed, or clears on init.
// ============================================================================
`default_nettype none

module sa_cell
    import sa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] pos,
    input  wire cell_cmd_t        cmd,
    input  wire seg_t             left,
    input  wire seg_t             right,
    output seg_t                  seg
);

    seg_t seg_reg;
    seg_t seg_next;

    // Decode the broadcast command against this cell's position
    always_comb
    begin
        seg_next = seg_reg;
        unique case (cmd.op)
            CMD_INIT:
            begin
                seg_next = '0;
                if (pos == '0)
                begin
                    seg_next.len = cmd.seg.len;
                end
            end
            CMD_OPEN:
            begin
                if (pos > cmd.idx)
                begin
                    seg_next = left;
                end
            end
            CMD_DROP:
            begin
                if (pos >= cmd.idx)
                begin
                    seg_next = right;
                end
            end
            CMD_WRITE:
            begin
                if (pos == cmd.idx)
                begin
                    seg_next = cmd.seg;
                end
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    // Hold the entry; entry 0 comes out of reset as the whole default heap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= '{start: '0, len: (pos == '0) ? RESET_HEAP : '0, used: 1'b0};
        end
        else
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg = seg_reg;

endmodule

`default_nettype wire

// ===== rtl/sa_ctrl.sv =====
// ============================================================================
// sa_ctrl
// Request sequencer: walks the cell chain one entry per cycle, then issues
// split, merge and shift commands and returns one result per request.
// ============================================================================
`default_nettype none

module sa_ctrl
    import sa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [LEN_W-1:0]     wr_data,
    sa_req_if.sink                    req,
    sa_rsp_if.source                  rsp,
    input  wire seg_t [MAX_SEG-1:0]   cells,
    output cell_cmd_t                 cmd
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [LEN_W-1:0]     plen_reg, plen_next;
    logic [OFS_W-1:0]     pstart_reg, pstart_next;
    logic [POL_W-1:0]     policy_reg, policy_next;
    logic [LEN_W-1:0]     size_reg, size_next;
    logic [OFS_W-1:0]     ofs_reg, ofs_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [OFS_W-1:0]     grant_reg, grant_next;
    logic                 ovalid_reg, ovalid_next;
    logic [STAT_W-1:0]    ostatus_reg, ostatus_next;
    logic [OFS_W-1:0]     ogrant_reg, ogrant_next;

    logic [IDX_W-1:0]     rd_idx;
    seg_t                 rd;
    logic                 last;
    logic                 cand;
    logic                 better;
    logic [LEN_W-1:0]     heap_clamped;

    assign rd   = cells[rd_idx];
    assign last = ({1'b0, k_reg} + CNT_W'(1)) == count_reg;
    assign cand = !rd.used && (rd.len >= size_reg);
    assign better = ((policy_reg == POL_BEST) && (rd.len < plen_reg))
                 || ((policy_reg == POL_WORST) && (rd.len > plen_reg));

    // Clamp a written heap size into 1 .. 2^OFS_W
    always_comb
    begin
        heap_clamped = wr_data;
        if (wr_data == '0)
        begin
            heap_clamped = LEN_W'(1);
        end
        else if (wr_data > HEAP_MAX)
        begin
            heap_clamped = HEAP_MAX;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = ovalid_reg;
    assign rsp.status         = ostatus_reg;
    assign rsp.granted_offset = ogrant_reg;

    // Next state, cell commands and result
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        plen_next    = plen_reg;
        pstart_next  = pstart_reg;
        policy_next  = policy_reg;
        size_next    = size_reg;
        ofs_next     = ofs_reg;
        status_next  = status_reg;
        grant_next   = grant_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        ogrant_next  = ogrant_reg;
        rd_idx       = k_reg;
        cmd          = '0;
        cmd.op       = CMD_NONE;

        // Drop the result once taken
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (wr_en && (wr_index == REG_FIT_POLICY))
                begin
                    policy_next = wr_data[POL_W-1:0];
                end
                else if (wr_en && (wr_index == REG_HEAP_SIZE))
                begin
                    cmd.op      = CMD_INIT;
                    cmd.seg.len = heap_clamped;
                    count_next  = CNT_W'(1);
                end
                if (req.valid)
                begin
                    size_next   = req.alloc_size;
                    ofs_next    = req.free_offset;
                    k_next      = '0;
                    found_next  = 1'b0;
                    grant_next  = '0;
                    if (req.mode == MODE_FREE)
                    begin
                        state_next = S_FSCAN;
                    end
                    else if (req.alloc_size == '0)
                    begin
                        status_next = STAT_NOFIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                if (cand && (!found_reg || better))
                begin
                    found_next  = 1'b1;
                    pick_next   = k_reg;
                    plen_next   = rd.len;
                    pstart_next = rd.start;
                end
                if ((cand && !found_reg && (policy_reg != POL_BEST)
                     && (policy_reg != POL_WORST)) || last)
                begin
                    state_next = S_ADECIDE;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_ADECIDE:
            begin
                if (!found_reg)
                begin
                    status_next = STAT_NOFIT;
                    state_next  = S_DONE;
                end
                else if (plen_reg != size_reg)
                begin
                    if (count_reg == CNT_W'(MAX_SEG))
                    begin
                        status_next = STAT_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = CMD_OPEN;
                        cmd.idx    = pick_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_AWR_REM;
                    end
                end
                else
                begin
                    cmd.op      = CMD_WRITE;
                    cmd.idx     = pick_reg;
                    cmd.seg     = '{start: pstart_reg, len: plen_reg, used: 1'b1};
                    status_next = STAT_OK;
                    grant_next  = pstart_reg;
                    state_next  = S_DONE;
                end
            end
            S_AWR_REM:
            begin
                cmd.op        = CMD_WRITE;
                cmd.idx       = pick_reg + IDX_W'(1);
                cmd.seg.start = pstart_reg + size_reg[OFS_W-1:0];
                cmd.seg.len   = plen_reg - size_reg;
                cmd.seg.used  = 1'b0;
                state_next    = S_AWR_HEAD;
            end
            S_AWR_HEAD:
            begin
                cmd.op      = CMD_WRITE;
                cmd.idx     = pick_reg;
                cmd.seg     = '{start: pstart_reg, len: size_reg, used: 1'b1};
                status_next = STAT_OK;
                grant_next  = pstart_reg;
                state_next  = S_DONE;
            end
            S_FSCAN:
            begin
                if (rd.used && (rd.start == ofs_reg))
                begin
                    pick_next   = k_reg;
                    plen_next   = rd.len;
                    pstart_next = rd.start;
                    state_next  = S_FCLR;
                end
                else if (last)
                begin
                    status_next = STAT_BADOFS;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_FCLR:
            begin
                cmd.op     = CMD_WRITE;
                cmd.idx    = pick_reg;
                cmd.seg    = '{start: pstart_reg, len: plen_reg, used: 1'b0};
                state_next = S_FNEXT;
            end
            S_FNEXT:
            begin
                rd_idx = pick_reg + IDX_W'(1);
                if ((({1'b0, pick_reg} + CNT_W'(1)) < count_reg) && !rd.used)
                begin
                    cmd.op      = CMD_WRITE;
                    cmd.idx     = pick_reg;
                    cmd.seg     = '{start: pstart_reg, len: plen_reg + rd.len,
                                    used: 1'b0};
                    plen_next   = plen_reg + rd.len;
                    state_next  = S_FDROPN;
                end
                else
                begin
                    state_next = S_FPREV;
                end
            end
            S_FDROPN:
            begin
                cmd.op     = CMD_DROP;
                cmd.idx    = pick_reg + IDX_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = S_FPREV;
            end
            S_FPREV:
            begin
                rd_idx = pick_reg - IDX_W'(1);
                if ((pick_reg != '0) && !rd.used)
                begin
                    cmd.op     = CMD_WRITE;
                    cmd.idx    = pick_reg - IDX_W'(1);
                    cmd.seg    = '{start: rd.start, len: rd.len + plen_reg,
                                   used: 1'b0};
                    state_next = S_FDROPK;
                end
                else
                begin
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                end
            end
            S_FDROPK:
            begin
                cmd.op      = CMD_DROP;
                cmd.idx     = pick_reg;
                count_next  = count_reg - CNT_W'(1);
                status_next = STAT_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    ogrant_next  = (status_reg == STAT_OK) ? grant_reg : '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= CNT_W'(1);
            policy_reg <= POL_FIRST;
            ovalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            policy_reg <= policy_next;
            ovalid_reg <= ovalid_next;
            found_reg  <= found_next;
            k_reg      <= k_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pick_reg    <= pick_next;
        plen_reg    <= plen_next;
        pstart_reg  <= pstart_next;
        size_reg    <= size_next;
        ofs_reg     <= ofs_next;
        status_reg  <= status_next;
        grant_reg   <= grant_next;
        ostatus_reg <= ostatus_next;
        ogrant_reg  <= ogrant_next;
    end

    // Table occupancy stays within one and the chain length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_SEG)))
        else $error("segment count out of range");

    // Scans only visit live entries
    a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ASCAN) || (state_reg == S_FSCAN))
        |-> ({1'b0, k_reg} < count_reg))
        else $error("scan beyond table end");

    // A split only opens a slot when the table has room
    a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_OPEN) |-> (count_reg < CNT_W'(MAX_SEG)))
        else $error("split on full table");

    // A result is loaded only on leaving the done state
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(ovalid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

endmodule

`default_nettype wire

// ===== rtl/segment_allocator_fit_policies.sv =====
// ============================================================================
// segment_allocator_fit_policies
// Heap segment allocator with first, best and worst fit, built as a chain
// of entry cells driven by a request sequencer.
//
//   channel   dir   handshake      payload
//   req       in    valid/ready    mode, alloc_size, free_offset
//   rsp       out   valid/ready    status, granted_offset
//   wr_*      in    wr_en          wr_index, wr_data (no read-back)
//
// One request at a time. A request walks the cell chain one entry per cycle,
// up to the table count of 32 entries.
// After reset the table holds one free segment of 128 units.
// A waiting result in the output register does not block a new request;
// a finished request holds in its done state until the register frees.
// ============================================================================
`default_nettype none

module segment_allocator_fit_policies
    import sa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [LEN_W-1:0]     wr_data,
    sa_req_if.sink                    req,
    sa_rsp_if.source                  rsp
);

    seg_t [MAX_SEG-1:0] cells;
    cell_cmd_t          cmd;

    sa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req),
        .rsp      (rsp),
        .cells    (cells),
        .cmd      (cmd)
    );

    // Build the chain; the ends see empty neighbors
    for (genvar j = 0; j < MAX_SEG; j++)
    begin : g_cell
        seg_t lnb;
        seg_t rnb;
        if (j == 0)
        begin : g_lend
            assign lnb = '0;
        end
        else
        begin : g_lmid
            assign lnb = cells[j-1];
        end
        if (j == MAX_SEG - 1)
        begin : g_rend
            assign rnb = '0;
        end
        else
        begin : g_rmid
            assign rnb = cells[j+1];
        end

        sa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .pos   (IDX_W'(j)),
            .cmd   (cmd),
            .left  (lnb),
            .right (rnb),
            .seg   (cells[j])
        );
    end

endmodule

`default_nettype wire

// ===== test/sa_tb_scoreboard.sv =====
// ============================================================================
// sa_tb_scoreboard
// Tracks the segment table of the allocator and checks each result against
// the status and offset predicted for the oldest outstanding request.
// ============================================================================
`default_nettype none

package sa_tb_pkg;
    import sa_pkg::*;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] alloc_size;
        logic [OFS_W-1:0] free_offset;
    } sa_request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFS_W-1:0]  granted_offset;
    } sa_result_t;

    class heap_tracker;
        logic [POL_W-1:0] policy;
        logic [LEN_W-1:0] total;
        logic [OFS_W-1:0] seg_start [MAX_SEG];
        logic [LEN_W-1:0] seg_len [MAX_SEG];
        bit               seg_used [MAX_SEG];
        int               seg_count;
        sa_result_t       pending [$];
        int               errors;

        function new();
            policy = POL_FIRST;
            total  = RESET_HEAP;
            errors = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int k = 0; k < MAX_SEG; k++)
            begin
                seg_start[k] = '0;
                seg_len[k]   = '0;
                seg_used[k]  = 0;
            end
            seg_len[0] = (total == 0) ? LEN_W'(1) : (total > HEAP_MAX ? HEAP_MAX : total);
            seg_count  = 1;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
            if (idx == REG_FIT_POLICY)
            begin
                policy = value[POL_W-1:0];
            end
            else
            begin
                total = value;
                rebuild();
            end
        endfunction

        // Remove entry idx and shift the tail down
        function void remove_at(int idx);
            for (int k = idx; k + 1 < seg_count; k++)
            begin
                seg_start[k] = seg_start[k+1];
                seg_len[k]   = seg_len[k+1];
                seg_used[k]  = seg_used[k+1];
            end
            seg_count--;
            seg_start[seg_count] = '0;
            seg_len[seg_count]   = '0;
            seg_used[seg_count]  = 0;
        endfunction

        function sa_result_t allocate(logic [LEN_W-1:0] size);
            sa_result_t r;
            int pick;
            r = '{status: STAT_NOFIT, granted_offset: '0};
            pick = -1;
            if (size == 0)
            begin
                return r;
            end
            for (int k = 0; k < seg_count; k++)
            begin
                if (seg_used[k] || seg_len[k] < size)
                begin
                    continue;
                end
                if (pick < 0)
                begin
                    pick = k;
                    if (policy != POL_BEST && policy != POL_WORST)
                    begin
                        break;
                    end
                end
                else if (policy == POL_BEST && seg_len[k] < seg_len[pick])
                begin
                    pick = k;
                end
                else if (policy == POL_WORST && seg_len[k] > seg_len[pick])
                begin
                    pick = k;
                end
            end
            if (pick < 0)
            begin
                return r;
            end
            if (seg_len[pick] != size)
            begin
                if (seg_count >= MAX_SEG)
                begin
                    r.status = STAT_FULL;
                    return r;
                end
                // Open a slot after the pick for the free remainder
                for (int k = seg_count; k > pick + 1; k--)
                begin
                    seg_start[k] = seg_start[k-1];
                    seg_len[k]   = seg_len[k-1];
                    seg_used[k]  = seg_used[k-1];
                end
                seg_count++;
                seg_start[pick+1] = seg_start[pick] + size[OFS_W-1:0];
                seg_len[pick+1]   = seg_len[pick] - size;
                seg_used[pick+1]  = 0;
                seg_len[pick]     = size;
            end
            seg_used[pick] = 1;
            r.status = STAT_OK;
            r.granted_offset = seg_start[pick];
            return r;
        endfunction

        function sa_result_t release_at(logic [OFS_W-1:0] ofs);
            sa_result_t r;
            int k;
            r = '{status: STAT_BADOFS, granted_offset: '0};
            for (k = 0; k < seg_count; k++)
            begin
                if (seg_start[k] == ofs && seg_used[k])
                begin
                    break;
                end
            end
            if (k >= seg_count)
            begin
                return r;
            end
            seg_used[k] = 0;
            if (k + 1 < seg_count && !seg_used[k+1])
            begin
                seg_len[k] += seg_len[k+1];
                remove_at(k + 1);
            end
            if (k > 0 && !seg_used[k-1])
            begin
                seg_len[k-1] += seg_len[k];
                remove_at(k);
            end
            r.status = STAT_OK;
            return r;
        endfunction

        // Note an accepted request and queue its expected result
        function void note_request(sa_request_t q);
            if (q.mode == MODE_ALLOC)
            begin
                pending.push_back(allocate(q.alloc_size));
            end
            else
            begin
                pending.push_back(release_at(q.free_offset));
            end
        endfunction

        // Pick a start of some in-use segment, or any offset if none
        function logic [OFS_W-1:0] some_used_start();
            int cand [$];
            for (int k = 0; k < seg_count; k++)
            begin
                if (seg_used[k])
                begin
                    cand.push_back(k);
                end
            end
            if (cand.size() == 0)
            begin
                return OFS_W'($urandom);
            end
            return seg_start[cand[$urandom_range(cand.size() - 1)]];
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        function void check_result(sa_result_t got);
            sa_result_t exp;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result status %0d offset %0d",
                                 got.status, got.granted_offset));
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
            begin
                report($sformatf("status got %0d want %0d", got.status, exp.status));
            end
            if (got.granted_offset !== exp.granted_offset)
            begin
                report($sformatf("granted_offset got %0d want %0d",
                                 got.granted_offset, exp.granted_offset));
            end
        endfunction
    endclass
endpackage

`default_nettype wire

// ===== test/tb_segment_allocator_fit_policies.sv =====
// ============================================================================
// tb_segment_allocator_fit_policies
// Drives allocate and free requests through several policy and heap-size
// settings with random gaps on both channels, and checks every result.
// ============================================================================
`default_nettype none

module tb_segment_allocator_fit_policies;
    import sa_pkg::*;
    import sa_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [LEN_W-1:0] wr_data = '0;
    int cycles = 0;
    bit stim_done = 0;

    sa_req_if req ();
    sa_rsp_if rsp ();

    heap_tracker heap = new();

    segment_allocator_fit_policies i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    always #1 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.mode = MODE_ALLOC;
        req.alloc_size = '0;
        req.free_offset = '0;
        rsp.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(3);
        return $urandom_range(40);
    endfunction

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && req.valid && req.ready)
        begin
            heap.note_request('{mode: req.mode, alloc_size: req.alloc_size,
                                free_offset: req.free_offset});
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            heap.check_result('{status: rsp.status, granted_offset: rsp.granted_offset});
        end
    end

    // Result side stall pattern: one update per falling edge
    initial
    begin
        int n;
        n = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                n--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                n = gap_len();
            end
        end
    end

    // Present one request; returns at the falling edge after its transfer
    task automatic send(logic mode, logic [LEN_W-1:0] size, logic [OFS_W-1:0] ofs);
        int gap;
        gap = gap_len();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= mode;
        req.alloc_size <= size;
        req.free_offset <= ofs;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
        // drain outstanding results, then let the sequencer settle
        req.valid <= 1'b0;
        while (heap.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        heap.set_reg(idx, value);
    endtask

    task automatic random_phase(int count, int big);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                send(MODE_ALLOC, (r < 3) ? LEN_W'($urandom) :
                     LEN_W'($urandom_range(big)), OFS_W'($urandom));
            end
            else if (r < 88)
            begin
                send(MODE_FREE, LEN_W'($urandom), heap.some_used_start());
            end
            else
            begin
                send(MODE_FREE, LEN_W'($urandom), OFS_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: reset heap, extremes, zero size, bad free, split and merge
        send(MODE_ALLOC, 17'd0, 16'd0);
        send(MODE_ALLOC, 17'd129, 16'd0);
        send(MODE_ALLOC, 17'd10, 16'd0);
        send(MODE_ALLOC, 17'd20, 16'd0);
        send(MODE_ALLOC, 17'd30, 16'd0);
        send(MODE_FREE, 17'd0, 16'd10);
        send(MODE_FREE, 17'd0, 16'd10);
        send(MODE_FREE, 17'd0, 16'd5);
        send(MODE_FREE, 17'd0, 16'd0);
        send(MODE_ALLOC, 17'd68, 16'd0);
        send(MODE_ALLOC, 17'd1, 16'd0);
        send(MODE_FREE, 17'h1FFFF, 16'hFFFF);
        send(MODE_FREE, 17'd0, 16'd30);
        send(MODE_FREE, 17'd0, 16'd60);
        send(MODE_FREE, 17'd0, 16'd0);
        // Table full: fill with single units
        write_reg(REG_HEAP_SIZE, 17'd40);
        for (int i = 0; i < 33; i++) send(MODE_ALLOC, 17'd1, 16'd0);
        write_reg(REG_HEAP_SIZE, 17'd0);
        send(MODE_ALLOC, 17'd1, 16'd0);
        send(MODE_ALLOC, 17'd1, 16'd0);
        write_reg(REG_HEAP_SIZE, 17'h1FFFF);
        send(MODE_ALLOC, 17'h10000, 16'd0);
        send(MODE_FREE, 17'd0, 16'd0);
        send(MODE_ALLOC, 17'h1FFFF, 16'd0);

        // Random phases over every policy and several heap sizes
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_FIT_POLICY, LEN_W'(p % 4) | (LEN_W'($urandom) & ~LEN_W'(3)));
            case (p % 4)
                0: write_reg(REG_HEAP_SIZE, 17'd128);
                1: write_reg(REG_HEAP_SIZE, 17'h10000);
                2: write_reg(REG_HEAP_SIZE, 17'd1000);
                default: write_reg(REG_HEAP_SIZE, 17'd1);
            endcase
            random_phase(120, (p % 4 == 1) ? 6000 : 40);
        end
        req.valid <= 1'b0;
        stim_done = 1;
    end

    // End of run: drain, settle, report
    initial
    begin
        wait (stim_done);
        while (heap.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
        repeat (100) @(posedge clk);
        if (heap.errors == 0 && heap.pending.size() == 0)
        begin
            $display("** segment_allocator_fit_policies: PASSED **");
        end
        else
        begin
            $display("** segment_allocator_fit_policies: FAILED **");
        end
        $finish;
    end

    // Timeout guard
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("** segment_allocator_fit_policies: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
